// ===== rtl/irqt_pkg.sv =====
`timescale 1ns / 1ps

package irqt_pkg;

   // pixel word and register widths
   localparam int PIXEL_BITS = 8;
   localparam int CFG_BITS   = 9;
   localparam int CSR_BITS   = 2;

   // register indexes
   localparam logic [CSR_BITS-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_QUARTER_TURNS = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_TURN_LEFT     = 2'd3;

   // request actions
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // effective clockwise turn codes
   localparam logic [1:0] TURN_0   = 2'd0;
   localparam logic [1:0] TURN_90  = 2'd1;
   localparam logic [1:0] TURN_180 = 2'd2;
   localparam logic [1:0] TURN_270 = 2'd3;

   typedef struct packed {
      logic                  action;
      logic [PIXEL_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic [CFG_BITS-1:0]   out_columns;
      logic [CFG_BITS-1:0]   out_rows;
      logic                  row_end;
      logic                  frame_end;
   } rsp_type;

endpackage

// ===== rtl/image_rotate_quarter_turns_unit.sv =====
`timescale 1ns / 1ps

// Quarter-turn image rotator. A write request (action 0) stores pixel_in at the
// next raster position of a frame_width x frame_height frame; a read request
// (action 1) returns the next pixel of that frame turned clockwise by
// quarter_turns * 90 degrees (turn_left swaps 90 and 270), together with the
// turned frame's size and end-of-row / end-of-frame flags. Both positions wrap
// after the last pixel of the frame, and dimensions are clamped to 1..MAX_DIM.
// One request per clock is taken while the result side keeps up, set by the
// single write port and the single read port of the frame store. A read
// result passes through the synchronous store read and then the output
// register. Reading a location never written returns whatever the store
// holds. Configure only while the block is idle.

module image_rotate_quarter_turns_unit #(
   parameter int MAX_DIM = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  irqt_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output irqt_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [irqt_pkg::CSR_BITS-1:0] csr_index,
   input  logic [irqt_pkg::CFG_BITS-1:0] csr_write_data
);
   import irqt_pkg::*;

   // coordinate, clamped dimension and store address widths
   localparam int DIM_BITS  = $clog2(MAX_DIM);
   localparam int LW        = DIM_BITS + 1;
   localparam int ADDR_BITS = 2 * DIM_BITS;

   // configuration registers
   logic [CFG_BITS-1:0] frame_width_ff, frame_width_in;
   logic [CFG_BITS-1:0] frame_height_ff, frame_height_in;
   logic [1:0]          quarter_turns_ff, quarter_turns_in;
   logic                turn_left_ff, turn_left_in;

   // raster positions
   logic [DIM_BITS-1:0] load_row_ff, load_row_in;
   logic [DIM_BITS-1:0] load_col_ff, load_col_in;
   logic [DIM_BITS-1:0] read_row_ff, read_row_in;
   logic [DIM_BITS-1:0] read_col_ff, read_col_in;

   // read stage: store access in flight
   logic                s1_valid_ff, s1_valid_in;
   logic [CFG_BITS-1:0] s1_cols_ff, s1_cols_in;
   logic [CFG_BITS-1:0] s1_rows_ff, s1_rows_in;
   logic                s1_row_end_ff, s1_row_end_in;
   logic                s1_frame_end_ff, s1_frame_end_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // handshake
   logic s1_advance;
   logic req_accept;
   logic wr_en;
   logic rd_en;

   // clamped dimensions and turned geometry
   logic [LW-1:0]       width_lim, height_lim;
   logic [1:0]          turns;
   logic [LW-1:0]       ocols, orows;

   // load side
   logic [DIM_BITS-1:0] ld_row, ld_col;
   logic                ld_last_col, ld_last_row;

   // read side
   logic [DIM_BITS-1:0] rd_row, rd_col;
   logic [LW-1:0]       src_row, src_col;
   logic                rd_last_col, rd_last_row;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [PIXEL_BITS-1:0] mem_q;

   // clamp frame dimensions to 1..MAX_DIM
   always_comb begin
      if (frame_width_ff == '0) begin
         width_lim = LW'(1);
      end else if (int'(frame_width_ff) > MAX_DIM) begin
         width_lim = LW'(MAX_DIM);
      end else begin
         width_lim = LW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_lim = LW'(1);
      end else if (int'(frame_height_ff) > MAX_DIM) begin
         height_lim = LW'(MAX_DIM);
      end else begin
         height_lim = LW'(frame_height_ff);
      end
   end

   // a left turn by n is a right turn by 4-n
   assign turns = turn_left_ff ? 2'(2'd0 - quarter_turns_ff) : quarter_turns_ff;
   assign ocols = turns[0] ? height_lim : width_lim;
   assign orows = turns[0] ? width_lim : height_lim;

   // flow control: the read stage may only be refilled once it moves on
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_data.action == ACTION_WRITE);
   assign rd_en      = req_accept && (req_data.action == ACTION_READ);

   // load position, pulled back into the frame if dimensions shrank
   always_comb begin
      ld_row      = ({1'b0, load_row_ff} >= height_lim) ? '0 : load_row_ff;
      ld_col      = ({1'b0, load_col_ff} >= width_lim) ? '0 : load_col_ff;
      ld_last_col = ({1'b0, ld_col} == width_lim - LW'(1));
      ld_last_row = ({1'b0, ld_row} == height_lim - LW'(1));
      wr_addr     = {ld_row, ld_col};
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      if (wr_en) begin
         if (ld_last_col) begin
            load_col_in = '0;
            load_row_in = ld_last_row ? '0 : ld_row + DIM_BITS'(1);
         end else begin
            load_col_in = ld_col + DIM_BITS'(1);
            load_row_in = ld_row;
         end
      end
   end

   // read position and source pixel of the turned frame
   always_comb begin
      rd_row      = ({1'b0, read_row_ff} >= orows) ? '0 : read_row_ff;
      rd_col      = ({1'b0, read_col_ff} >= ocols) ? '0 : read_col_ff;
      rd_last_col = ({1'b0, rd_col} == ocols - LW'(1));
      rd_last_row = ({1'b0, rd_row} == orows - LW'(1));
      unique case (turns)
         TURN_0: begin
            src_row = {1'b0, rd_row};
            src_col = {1'b0, rd_col};
         end
         TURN_90: begin
            // output row r is input column r, bottom to top
            src_row = height_lim - LW'(1) - {1'b0, rd_col};
            src_col = {1'b0, rd_row};
         end
         TURN_180: begin
            src_row = height_lim - LW'(1) - {1'b0, rd_row};
            src_col = width_lim - LW'(1) - {1'b0, rd_col};
         end
         TURN_270: begin
            // output row r is input column width-1-r, top to bottom
            src_row = {1'b0, rd_col};
            src_col = width_lim - LW'(1) - {1'b0, rd_row};
         end
         default: begin
            src_row = '0;
            src_col = '0;
         end
      endcase
      rd_addr     = {src_row[DIM_BITS-1:0], src_col[DIM_BITS-1:0]};
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      if (rd_en) begin
         if (rd_last_col) begin
            read_col_in = '0;
            read_row_in = rd_last_row ? '0 : rd_row + DIM_BITS'(1);
         end else begin
            read_col_in = rd_col + DIM_BITS'(1);
            read_row_in = rd_row;
         end
      end
   end

   // read stage and output register
   always_comb begin
      s1_valid_in     = rd_en || (s1_valid_ff && !s1_advance);
      s1_cols_in      = s1_cols_ff;
      s1_rows_in      = s1_rows_ff;
      s1_row_end_in   = s1_row_end_ff;
      s1_frame_end_in = s1_frame_end_ff;
      if (rd_en) begin
         s1_cols_in      = CFG_BITS'(ocols);
         s1_rows_in      = CFG_BITS'(orows);
         s1_row_end_in   = rd_last_col;
         s1_frame_end_in = rd_last_col && rd_last_row;
      end
      rsp_valid_in = s1_valid_ff || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (s1_valid_ff && s1_advance) begin
         rsp_data_in.pixel_out   = mem_q;
         rsp_data_in.out_columns = s1_cols_ff;
         rsp_data_in.out_rows    = s1_rows_ff;
         rsp_data_in.row_end     = s1_row_end_ff;
         rsp_data_in.frame_end   = s1_frame_end_ff;
      end
   end

   // configuration writes
   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      quarter_turns_in = quarter_turns_ff;
      turn_left_in     = turn_left_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_in   = csr_write_data;
            CSR_FRAME_HEIGHT:  frame_height_in  = csr_write_data;
            CSR_QUARTER_TURNS: quarter_turns_in = csr_write_data[1:0];
            CSR_TURN_LEFT:     turn_left_in     = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= CFG_BITS'(1);
         frame_height_ff  <= CFG_BITS'(1);
         quarter_turns_ff <= '0;
         turn_left_ff     <= 1'b0;
         load_row_ff      <= '0;
         load_col_ff      <= '0;
         read_row_ff      <= '0;
         read_col_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         quarter_turns_ff <= quarter_turns_in;
         turn_left_ff     <= turn_left_in;
         load_row_ff      <= load_row_in;
         load_col_ff      <= load_col_in;
         read_row_ff      <= read_row_in;
         read_col_ff      <= read_col_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_cols_ff      <= s1_cols_in;
      s1_rows_ff      <= s1_rows_in;
      s1_row_end_ff   <= s1_row_end_in;
      s1_frame_end_ff <= s1_frame_end_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // frame store: writes at the load position, reads at the turned position
   irqt_store #(
      .ADDR_BITS (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/irqt_store.sv =====
`timescale 1ns / 1ps

module irqt_store #(
   parameter int ADDR_BITS = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  logic [irqt_pkg::PIXEL_BITS-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   output logic [irqt_pkg::PIXEL_BITS-1:0] rd_data
);
   import irqt_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [PIXEL_BITS-1:0] store_ff [DEPTH];
   logic [PIXEL_BITS-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = q_ff;

endmodule

// ===== rtl/irqt_checker.sv =====
`timescale 1ns / 1ps

module irqt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input irqt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input irqt_pkg::rsp_type rsp_data
);
   import irqt_pkg::*;

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a fresh result follows an accepted read request, through the read stage and the output register
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && req_data.action == ACTION_READ, 2))
      else $error("result without a read request");

   // last pixel of the frame is also last of its row
   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.row_end)
      else $error("frame end without row end");

   // requests are held back only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stall without a stalled result");

endmodule

bind image_rotate_quarter_turns_unit irqt_checker u_irqt_checker (.*);
